>>> hdl/bmtc_pkg.sv
// bmtc_pkg: shared types and constants of the bit matrix transitive closure block
// used by bmtc_cell and bit_matrix_transitive_closure; no dependencies
`timescale 1ns / 1ps

package bmtc_pkg;

  localparam int unsigned NODES  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned DATA_W = 24;

  typedef logic [NODES-1:0]  row_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    logic  load_en;
    idx_t  load_idx;
    row_t  load_bits;
    logic  mask_en;
    row_t  col_mask;
    size_t nodes;
    logic  close_en;
    idx_t  pivot_idx;
    row_t  pivot_row;
    logic  shift_en;
  } cell_ctrl_t;

  function automatic row_t col_mask(input size_t n);
    row_t m;
    for (int j = 0; j < NODES; j++) begin
      m[j] = (SIZE_W'(j) < n);
    end
    return m;
  endfunction

endpackage

>>> hdl/bmtc_cell.sv
// bmtc_cell: one matrix row of the closure chain, load, mask, pivot update and shift
// depends on bmtc_pkg
`timescale 1ns / 1ps

module bmtc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmtc_pkg::idx_t      cell_idx_i,
  input  bmtc_pkg::cell_ctrl_t ctrl_i,
  input  bmtc_pkg::row_t      shift_in_i,
  output bmtc_pkg::row_t      row_o
);
  import bmtc_pkg::*;

  row_t row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.load_en && (ctrl_i.load_idx == cell_idx_i)) begin
      row_d = ctrl_i.load_bits;
    end
    if (ctrl_i.mask_en) begin
      row_d = ({1'b0, cell_idx_i} < ctrl_i.nodes) ? (row_d & ctrl_i.col_mask) : '0;
    end
    if (ctrl_i.close_en && row_q[ctrl_i.pivot_idx]) begin
      row_d = row_q | ctrl_i.pivot_row;
    end
    if (ctrl_i.shift_en) begin
      row_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

>>> hdl/bit_matrix_transitive_closure.sv
// Transitive closure of a directed graph of up to 16 nodes held as a bit matrix.
// Rows load one per cycle while s_axis_tready_o is high; a row index at or beyond
// the node count n is dropped and columns at or beyond n are cleared. The word with
// tlast set starts the closure: one pivot per cycle, pivots 0 to n-1 in turn, the
// pivot row picked by a 16-to-1 mux and broadcast to a chain of 16 row cells that
// update in parallel. The closed rows 0 to n-1 then leave one per cycle while
// m_axis_tready_i is high, from the head of the chain as it shifts toward it,
// which also empties the store for the next matrix.
// With n = 0 the final word causes no output and the store is simply cleared.
// depends on bmtc_pkg and bmtc_cell
`timescale 1ns / 1ps

module bit_matrix_transitive_closure (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  bmtc_pkg::size_t              cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // row_index [3:0], row_bits [19:4], zero [23:20]
  input  logic [bmtc_pkg::DATA_W-1:0]  s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_index [3:0], out_bits [19:4], zero [23:20]
  output logic [bmtc_pkg::DATA_W-1:0]  m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import bmtc_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_CLOSE, ST_EMIT} state_e;

  state_e     state_q;
  size_t      size_q;
  idx_t       piv_q;
  idx_t       emit_q;
  size_t      nodes;
  idx_t       nodes_m1;
  row_t       cmask;
  idx_t       in_idx;
  row_t       in_bits;
  logic       in_acc;
  logic       out_acc;
  cell_ctrl_t ctrl;
  row_t       rows [NODES];

  assign nodes    = (size_q > SIZE_W'(NODES)) ? SIZE_W'(NODES) : size_q;
  assign nodes_m1 = IDX_W'(nodes - SIZE_W'(1));
  assign cmask    = col_mask(nodes);
  assign in_idx   = s_axis_tdata_i[IDX_W-1:0];
  assign in_bits  = s_axis_tdata_i[IDX_W +: NODES];

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    ctrl.load_en   = in_acc && ({1'b0, in_idx} < nodes);
    ctrl.load_idx  = in_idx;
    ctrl.load_bits = in_bits & cmask;
    ctrl.mask_en   = in_acc && s_axis_tlast_i;
    ctrl.col_mask  = cmask;
    ctrl.nodes     = nodes;
    ctrl.close_en  = (state_q == ST_CLOSE);
    ctrl.pivot_idx = piv_q;
    ctrl.pivot_row = rows[piv_q];
    ctrl.shift_en  = out_acc;
  end

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    row_t shift_in;
    if (i == NODES - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_link
      assign shift_in = rows[i+1];
    end
    bmtc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .shift_in_i (shift_in),
      .row_o      (rows[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(NODES);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      piv_q   <= '0;
      emit_q  <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc && s_axis_tlast_i && (nodes != '0)) begin
            state_q <= ST_CLOSE;
            piv_q   <= '0;
          end
        end
        ST_CLOSE: begin
          if (piv_q == nodes_m1) begin
            state_q <= ST_EMIT;
            emit_q  <= '0;
          end else begin
            piv_q <= piv_q + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (emit_q == nodes_m1) begin
              state_q <= ST_LOAD;
            end else begin
              emit_q <= emit_q + IDX_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tdata_o = {(DATA_W - NODES - IDX_W)'(0), rows[0], emit_q};
  assign m_axis_tlast_o = (emit_q == nodes_m1);

`ifndef SYNTHESIS
  a_no_load_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE) |-> !s_axis_tready_o)
    else $error("input taken during closure");

  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("no return to loading after final row");

  a_start_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i && (nodes != '0)) |=> (state_q == ST_CLOSE && piv_q == '0))
    else $error("closure did not start at pivot zero");

  a_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> (rows[0] == '0))
    else $error("row store not empty after emission");
`endif

endmodule
